>>> hdl/sfp_pkg.sv
package sfp_pkg;

   // largest declared frame size; a length byte must stay below it
   localparam int unsigned MAX_FRAME = 32;

   // field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CODE_W   = 7;
   localparam int unsigned LEN_W    = 5;
   localparam int unsigned STATUS_W = 2;

   // length bytes must be below both MAX_FRAME and the reach of the length field
   localparam int unsigned LEN_SPAN  = 1 << LEN_W;
   localparam int unsigned LEN_LIMIT = (MAX_FRAME < LEN_SPAN) ? MAX_FRAME : LEN_SPAN;

   // request kinds carried on tuser
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // valid protocol version and the reserved command bit
   localparam logic [BYTE_W-1:0] VERSION_OK   = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_RESERVED = 8'h80;

   // packed response data width, whole bytes
   localparam int unsigned RSP_FIELDS_W = STATUS_W + BYTE_W + CODE_W + LEN_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADVER  = 2'd1,
      ST_BADCMD  = 2'd2,
      ST_TOOLONG = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_VER  = 5'b00010,
      PH_CMD  = 5'b00100,
      PH_LEN  = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [CODE_W-1:0] held_code;
      logic [LEN_W-1:0]  held_length;
      logic [LEN_W-1:0]  byte_count;
   } parse_state_type;

   typedef struct packed {
      status_type        status;
      logic              has_payload;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_end;
      logic [CODE_W-1:0] request_code;
      logic [LEN_W-1:0]  payload_length;
   } result_type;

endpackage

>>> hdl/sfp_decode.sv
module sfp_decode (
   input  sfp_pkg::parse_state_type    cur_state,
   input  logic                        command,
   input  logic [sfp_pkg::BYTE_W-1:0]  rx_byte,
   output sfp_pkg::parse_state_type    nxt_state,
   output logic                        emit,
   output sfp_pkg::result_type         result
);

   logic [sfp_pkg::LEN_W-1:0] count_inc;
   logic                      len_bad;

   assign count_inc = cur_state.byte_count + sfp_pkg::LEN_W'(1);
   assign len_bad   = {1'b0, rx_byte} >= 9'(sfp_pkg::LEN_LIMIT);

   // per-byte frame decisions
   always_comb begin
      nxt_state             = cur_state;
      emit                  = 1'b0;
      result.status         = sfp_pkg::ST_OK;
      result.has_payload    = 1'b0;
      result.payload_byte   = '0;
      result.frame_end      = 1'b0;

      if (command == sfp_pkg::CMD_BEGIN) begin
         nxt_state.phase       = sfp_pkg::PH_VER;
         nxt_state.held_code   = '0;
         nxt_state.held_length = '0;
         nxt_state.byte_count  = '0;
      end else begin
         unique case (cur_state.phase)
            sfp_pkg::PH_VER: begin
               if (rx_byte != sfp_pkg::VERSION_OK) begin
                  nxt_state.phase  = sfp_pkg::PH_IDLE;
                  emit             = 1'b1;
                  result.status    = sfp_pkg::ST_BADVER;
                  result.frame_end = 1'b1;
               end else begin
                  nxt_state.phase = sfp_pkg::PH_CMD;
               end
            end
            sfp_pkg::PH_CMD: begin
               if ((rx_byte & sfp_pkg::CMD_RESERVED) != '0) begin
                  nxt_state.phase  = sfp_pkg::PH_IDLE;
                  emit             = 1'b1;
                  result.status    = sfp_pkg::ST_BADCMD;
                  result.frame_end = 1'b1;
               end else begin
                  nxt_state.held_code = rx_byte[sfp_pkg::CODE_W-1:0];
                  nxt_state.phase     = sfp_pkg::PH_LEN;
               end
            end
            sfp_pkg::PH_LEN: begin
               if (len_bad) begin
                  nxt_state.phase  = sfp_pkg::PH_IDLE;
                  emit             = 1'b1;
                  result.status    = sfp_pkg::ST_TOOLONG;
                  result.frame_end = 1'b1;
               end else begin
                  nxt_state.held_length = rx_byte[sfp_pkg::LEN_W-1:0];
                  nxt_state.byte_count  = '0;
                  if (rx_byte[sfp_pkg::LEN_W-1:0] == '0) begin
                     // empty frame ends right at the header
                     nxt_state.phase  = sfp_pkg::PH_IDLE;
                     emit             = 1'b1;
                     result.frame_end = 1'b1;
                  end else begin
                     nxt_state.phase = sfp_pkg::PH_DATA;
                  end
               end
            end
            sfp_pkg::PH_DATA: begin
               nxt_state.byte_count = count_inc;
               emit                 = 1'b1;
               result.has_payload   = 1'b1;
               result.payload_byte  = rx_byte;
               if (count_inc >= cur_state.held_length) begin
                  nxt_state.phase  = sfp_pkg::PH_IDLE;
                  result.frame_end = 1'b1;
               end
            end
            default: begin
               // not armed: byte is dropped
               nxt_state = cur_state;
            end
         endcase
      end

      // header fields as held after this byte
      result.request_code   = nxt_state.held_code;
      result.payload_length = nxt_state.held_length;
   end

endmodule

>>> hdl/serial_request_frame_parser.sv
// channel   dir  fields
// req_      in   tuser: command; tdata: rx_byte
// rsp_      out  tuser: has_payload; tlast: frame_end;
//                tdata: status, payload_byte, request_code, payload_length
//
// one request per cycle sustained while rsp_tready stays high; a request is held in the
// input register, and any response it yields is then loaded into the response register
// reset clears the parser to idle (not armed) and empties both registers
// a stalled response holds the input register; req_tready drops only when both
// the input register and the response register are occupied
module serial_request_frame_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sfp_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] rx_byte
   input  logic                             req_tuser,   // [0] command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [1:0] status, [9:2] payload_byte,
                                                         // [16:10] request_code,
                                                         // [21:17] payload_length, rest zero
   output logic                             rsp_tuser,   // [0] has_payload
   output logic                             rsp_tlast    // frame_end
);

   logic                        req_valid_ff, req_valid_in;
   logic                        req_cmd_ff, req_cmd_in;
   logic [sfp_pkg::BYTE_W-1:0]  req_byte_ff, req_byte_in;
   sfp_pkg::parse_state_type    state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sfp_pkg::result_type         rsp_ff, rsp_in;

   sfp_pkg::parse_state_type    dec_state;
   logic                        dec_emit;
   sfp_pkg::result_type         dec_result;
   logic                        advance;
   logic                        take;

   // stage hand-off
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   sfp_decode u_decode (
      .cur_state (state_ff),
      .command   (req_cmd_ff),
      .rx_byte   (req_byte_ff),
      .nxt_state (dec_state),
      .emit      (dec_emit),
      .result    (dec_result)
   );

   // input register
   always_comb begin
      req_valid_in = req_valid_ff;
      req_cmd_in   = req_cmd_ff;
      req_byte_in  = req_byte_ff;
      if (take) begin
         req_valid_in = 1'b1;
         req_cmd_in   = req_tuser;
         req_byte_in  = req_tdata;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // parser state and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff && dec_emit;
         rsp_in       = dec_result;
         if (req_valid_ff) begin
            state_in = dec_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         state_ff.phase       <= sfp_pkg::PH_IDLE;
         state_ff.held_code   <= '0;
         state_ff.held_length <= '0;
         state_ff.byte_count  <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff  <= req_cmd_in;
      req_byte_ff <= req_byte_in;
      rsp_ff      <= rsp_in;
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.has_payload;
   assign rsp_tlast  = rsp_ff.frame_end;
   assign rsp_tdata  = sfp_pkg::RSP_DATA_W'({rsp_ff.payload_length, rsp_ff.request_code,
                                             rsp_ff.payload_byte, rsp_ff.status});

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS = 2000;
   localparam int unsigned STALL_LIMIT     = 2000;
   localparam int unsigned DRAIN_CYCLES    = 10;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [sfp_pkg::BYTE_W-1:0]     req_tdata;    // [7:0] rx_byte
   logic                           req_tuser;    // [0] command
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [sfp_pkg::RSP_DATA_W-1:0] rsp_tdata;    // [1:0] status, [9:2] payload_byte,
                                                 // [16:10] request_code,
                                                 // [21:17] payload_length
   logic                           rsp_tuser;    // [0] has_payload
   logic                           rsp_tlast;    // frame_end

   // parser state as the testbench tracks it
   sfp_pkg::phase_type         frame_phase;
   logic [sfp_pkg::CODE_W-1:0] code_seen;
   logic [sfp_pkg::LEN_W-1:0]  length_seen;
   logic [sfp_pkg::LEN_W-1:0]  payload_count;

   sfp_pkg::result_type expected_results[$];
   int unsigned         counted_requests;
   int unsigned         error_count;
   int unsigned         quiet_cycles;
   bit                  no_gaps;

   serial_request_frame_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // frame parser prediction for one accepted request
   task automatic predict_request(input logic cmd, input logic [sfp_pkg::BYTE_W-1:0] value);
      sfp_pkg::result_type r;
      bit                  has_result;
      r          = '0;
      has_result = 1'b0;
      if (!(cmd == sfp_pkg::CMD_BYTE && frame_phase == sfp_pkg::PH_IDLE))
         counted_requests++;
      if (cmd == sfp_pkg::CMD_BEGIN) begin
         frame_phase   = sfp_pkg::PH_VER;
         code_seen     = '0;
         length_seen   = '0;
         payload_count = '0;
      end else begin
         case (frame_phase)
            sfp_pkg::PH_VER: begin
               if (value != sfp_pkg::VERSION_OK) begin
                  frame_phase = sfp_pkg::PH_IDLE;
                  r.status    = sfp_pkg::ST_BADVER;
                  has_result  = 1'b1;
               end else begin
                  frame_phase = sfp_pkg::PH_CMD;
               end
            end
            sfp_pkg::PH_CMD: begin
               if ((value & sfp_pkg::CMD_RESERVED) != '0) begin
                  frame_phase = sfp_pkg::PH_IDLE;
                  r.status    = sfp_pkg::ST_BADCMD;
                  has_result  = 1'b1;
               end else begin
                  code_seen   = value[sfp_pkg::CODE_W-1:0];
                  frame_phase = sfp_pkg::PH_LEN;
               end
            end
            sfp_pkg::PH_LEN: begin
               // the length must fit both the frame limit and the length field
               if (value >= sfp_pkg::MAX_FRAME || value >= sfp_pkg::LEN_SPAN) begin
                  frame_phase = sfp_pkg::PH_IDLE;
                  r.status    = sfp_pkg::ST_TOOLONG;
                  has_result  = 1'b1;
               end else begin
                  length_seen   = value[sfp_pkg::LEN_W-1:0];
                  payload_count = '0;
                  if (length_seen == '0) begin
                     frame_phase = sfp_pkg::PH_IDLE;
                     r.status    = sfp_pkg::ST_OK;
                     has_result  = 1'b1;
                  end else begin
                     frame_phase = sfp_pkg::PH_DATA;
                  end
               end
            end
            sfp_pkg::PH_DATA: begin
               payload_count  = payload_count + sfp_pkg::LEN_W'(1);
               r.status       = sfp_pkg::ST_OK;
               r.has_payload  = 1'b1;
               r.payload_byte = value;
               has_result     = 1'b1;
               if (payload_count >= length_seen)
                  frame_phase = sfp_pkg::PH_IDLE;
            end
            default: ;
         endcase
         if (has_result) begin
            r.frame_end      = (frame_phase == sfp_pkg::PH_IDLE);
            r.request_code   = code_seen;
            r.payload_length = length_seen;
         end
      end
      if (has_result)
         expected_results.push_back(r);
   endtask

   // drive one request and wait for its handshake
   task automatic send_request(input logic cmd, input logic [sfp_pkg::BYTE_W-1:0] value);
      if (!no_gaps && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(cmd, value);
   endtask

   // hold off requests until every expected response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_idle_bytes();
      send_request(sfp_pkg::CMD_BYTE, 8'hFF);
      send_request(sfp_pkg::CMD_BYTE, 8'h00);
   endtask

   task automatic test_header_errors();
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, 8'h01);
      send_request(sfp_pkg::CMD_BEGIN, 8'hFF);
      send_request(sfp_pkg::CMD_BYTE, 8'hFF);
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::CMD_RESERVED);
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
      send_request(sfp_pkg::CMD_BYTE, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, 8'd32);
   endtask

   task automatic test_zero_length();
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
      send_request(sfp_pkg::CMD_BYTE, 8'h7F);
      send_request(sfp_pkg::CMD_BYTE, 8'h00);
   endtask

   // a begin in the middle of a payload drops the frame
   task automatic test_abort();
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
      send_request(sfp_pkg::CMD_BYTE, 8'h2A);
      send_request(sfp_pkg::CMD_BYTE, 8'h02);
      send_request(sfp_pkg::CMD_BYTE, 8'h00);
      send_request(sfp_pkg::CMD_BEGIN, 8'h00);
      send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
      send_request(sfp_pkg::CMD_BYTE, 8'h03);
      send_request(sfp_pkg::CMD_BYTE, 8'hFF);
   endtask

   // one frame, mostly well formed, sometimes broken or just noise
   task automatic send_random_frame();
      int unsigned kind;
      int unsigned count;
      int unsigned cut;
      kind = $urandom_range(0, 99);
      if (kind >= 96) begin
         count = $urandom_range(1, 4);
         repeat (count) send_request(sfp_pkg::CMD_BYTE, 8'($urandom));
      end else begin
         send_request(sfp_pkg::CMD_BEGIN, 8'($urandom));
         if (kind >= 80 && kind < 87) begin
            send_request(sfp_pkg::CMD_BYTE, 8'($urandom_range(1, 255)));
         end else begin
            send_request(sfp_pkg::CMD_BYTE, sfp_pkg::VERSION_OK);
            if (kind >= 87 && kind < 92) begin
               send_request(sfp_pkg::CMD_BYTE, sfp_pkg::CMD_RESERVED | 8'($urandom));
            end else begin
               send_request(sfp_pkg::CMD_BYTE, 8'($urandom_range(0, 127)));
               if (kind >= 92) begin
                  send_request(sfp_pkg::CMD_BYTE, 8'($urandom_range(32, 255)));
               end else begin
                  count = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 31);
                  send_request(sfp_pkg::CMD_BYTE, 8'(count));
                  // now and then the frame is cut short by a new begin
                  cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, count) : count;
                  repeat (cut) send_request(sfp_pkg::CMD_BYTE, 8'($urandom));
               end
            end
         end
      end
   endtask

   task automatic test_random_frames();
      int unsigned goal;
      int unsigned next_drain;
      goal       = counted_requests + RANDOM_REQUESTS;
      next_drain = counted_requests + 300;
      no_gaps    = 1'b1;
      while (counted_requests < goal) begin
         if (no_gaps && counted_requests > goal - RANDOM_REQUESTS + 400)
            no_gaps = 1'b0;
         if (counted_requests >= next_drain) begin
            drain_responses();
            next_drain = counted_requests + 300 + $urandom_range(0, 200);
         end
         send_random_frame();
      end
   endtask

   // compare one response field
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: random backpressure and checking
   always @(posedge clock) begin
      sfp_pkg::result_type want;
      want = '0;
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 8);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h", $time,
                     rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_tdata[9:2]));
            check_field("request_code", 32'(want.request_code), 32'(rsp_tdata[16:10]));
            check_field("payload_length", 32'(want.payload_length),
                        32'(rsp_tdata[21:17]));
            check_field("tdata padding", 0, 32'(rsp_tdata[sfp_pkg::RSP_DATA_W-1:22]));
            check_field("has_payload", 32'(want.has_payload), 32'(rsp_tuser));
            check_field("frame_end", 32'(want.frame_end), 32'(rsp_tlast));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tuser        = sfp_pkg::CMD_BEGIN;
      req_tdata        = '0;
      rsp_tready       = 1'b0;
      no_gaps          = 1'b0;
      quiet_cycles     = 0;
      error_count      = 0;
      counted_requests = 0;
      frame_phase      = sfp_pkg::PH_IDLE;
      code_seen        = '0;
      length_seen      = '0;
      payload_count    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_bytes();
      test_header_errors();
      test_zero_length();
      test_abort();
      test_random_frames();

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
